// ===== rtl/dtfe_pkg.sv =====
// Package for the diesel trip fuel economy block.
// Holds the register map, reset values, shared structs and fixed-point constants.
// Used by dtfe_cfg, dtfe_div and diesel_trip_fuel_economy; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package dtfe_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_RPM     = 3'd0,
    REG_MAX_DT_MS   = 3'd1,
    REG_AFR_BASE    = 3'd2,
    REG_AFR_SLOPE   = 3'd3,
    REG_AFR_FLOOR   = 3'd4,
    REG_MAF_COEFF   = 3'd5,
    REG_FUEL_DENS   = 3'd6,
    REG_ATM_KPA     = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [13:0] min_rpm;
    logic [15:0] max_dt_ms;
    logic [9:0]  afr_base_tenths;
    logic [7:0]  afr_slope_hundredths;
    logic [9:0]  afr_floor_tenths;
    logic [15:0] maf_coeff_micro;
    logic [10:0] fuel_density_gpl;
    logic [10:0] atm_tenths_kpa;
  } cfg_t;

  localparam logic [13:0] RST_MIN_RPM    = 14'd400;
  localparam logic [15:0] RST_MAX_DT_MS  = 16'd2000;
  localparam logic [9:0]  RST_AFR_BASE   = 10'd500;
  localparam logic [7:0]  RST_AFR_SLOPE  = 8'd32;
  localparam logic [9:0]  RST_AFR_FLOOR  = 10'd160;
  localparam logic [15:0] RST_MAF_COEFF  = 16'd1850;
  localparam logic [10:0] RST_FUEL_DENS  = 11'd835;
  localparam logic [10:0] RST_ATM_KPA    = 11'd1013;

  // Shared divider operand widths.
  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 48;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  localparam int FUEL_W = 48;
  localparam int DIST_W = 40;

  localparam logic [FUEL_W-1:0] FUEL_MAX    = {FUEL_W{1'b1}};
  localparam logic [DIST_W-1:0] DIST_MAX    = {DIST_W{1'b1}};
  localparam logic [FUEL_W-1:0] FUEL_MIN_NL = FUEL_W'(100000);
  localparam logic [10:0]       BOOST_MAX   = 11'd2047;

  localparam logic [13:0] TEMP_OFFSET   = 14'd2732;
  localparam logic [9:0]  NL_PER_UL     = 10'd1000;
  localparam logic [16:0] AVG_SCALE     = 17'd100000;
  // floor(2^32 / 18) for the millimetre conversion, corrected by one step.
  localparam logic [27:0] RECIP18       = 28'd238609294;
  localparam int          RECIP18_SHIFT = 32;
  localparam logic [4:0]  MM_DIVISOR    = 5'd18;

endpackage

`default_nettype wire

// ===== rtl/dtfe_cfg.sv =====
// Configuration register file of the diesel trip fuel economy block.
// Eight registers written over a valid/ready channel; depends on dtfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtfe_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [dtfe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [dtfe_pkg::CFG_DATA_W-1:0]   cfg_data,
  output dtfe_pkg::cfg_t                         cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_rpm              <= dtfe_pkg::RST_MIN_RPM;
      cfg.max_dt_ms            <= dtfe_pkg::RST_MAX_DT_MS;
      cfg.afr_base_tenths      <= dtfe_pkg::RST_AFR_BASE;
      cfg.afr_slope_hundredths <= dtfe_pkg::RST_AFR_SLOPE;
      cfg.afr_floor_tenths     <= dtfe_pkg::RST_AFR_FLOOR;
      cfg.maf_coeff_micro      <= dtfe_pkg::RST_MAF_COEFF;
      cfg.fuel_density_gpl     <= dtfe_pkg::RST_FUEL_DENS;
      cfg.atm_tenths_kpa       <= dtfe_pkg::RST_ATM_KPA;
    end else if (cfg_valid && cfg_ready) begin
      unique case (dtfe_pkg::cfg_reg_t'(cfg_index))
        dtfe_pkg::REG_MIN_RPM:   cfg.min_rpm              <= cfg_data[13:0];
        dtfe_pkg::REG_MAX_DT_MS: cfg.max_dt_ms            <= cfg_data[15:0];
        dtfe_pkg::REG_AFR_BASE:  cfg.afr_base_tenths      <= cfg_data[9:0];
        dtfe_pkg::REG_AFR_SLOPE: cfg.afr_slope_hundredths <= cfg_data[7:0];
        dtfe_pkg::REG_AFR_FLOOR: cfg.afr_floor_tenths     <= cfg_data[9:0];
        dtfe_pkg::REG_MAF_COEFF: cfg.maf_coeff_micro      <= cfg_data[15:0];
        dtfe_pkg::REG_FUEL_DENS: cfg.fuel_density_gpl     <= cfg_data[10:0];
        dtfe_pkg::REG_ATM_KPA:   cfg.atm_tenths_kpa       <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dtfe_div.sv =====
// Shared iterative restoring divider, one quotient bit per cycle.
// Used for both the fuel volume and the trip average; depends on dtfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtfe_div (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [dtfe_pkg::DIV_NUM_W-1:0]   num,
  input  wire logic [dtfe_pkg::DIV_DEN_W-1:0]   den,
  output logic [dtfe_pkg::DIV_NUM_W-1:0]        quot,
  output dtfe_pkg::div_stat_t                   stat
);

  logic [dtfe_pkg::DIV_DEN_W-1:0] rem;
  logic [dtfe_pkg::DIV_DEN_W-1:0] divisor;
  logic [dtfe_pkg::DIV_CNT_W-1:0] cnt;
  logic [dtfe_pkg::DIV_DEN_W:0]   shifted;
  logic                           fits;

  assign shifted = {rem, quot[dtfe_pkg::DIV_NUM_W-1]};
  assign fits    = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat.busy <= 1'b0;
      stat.done <= 1'b0;
    end else begin
      stat.done <= 1'b0;
      if (start && !stat.busy) begin
        stat.busy <= 1'b1;
        cnt       <= '0;
        quot      <= num;
        rem       <= '0;
        divisor   <= den;
      end else if (stat.busy) begin
        if (fits) begin
          rem <= dtfe_pkg::DIV_DEN_W'(shifted - {1'b0, divisor});
        end else begin
          rem <= shifted[dtfe_pkg::DIV_DEN_W-1:0];
        end
        quot <= {quot[dtfe_pkg::DIV_NUM_W-2:0], fits};
        cnt  <= cnt + 1'b1;
        if (cnt == {dtfe_pkg::DIV_CNT_W{1'b1}}) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/diesel_trip_fuel_economy.sv =====
// Diesel trip fuel economy estimator: top level with sequencer and datapath.
// Depends on dtfe_pkg, dtfe_cfg and dtfe_div.
// Gated, first or out-of-range items go from evaluation straight to the result; an accumulating item
// also runs the multiply states and up to two 64-step shared divider passes (fuel, then average).
// Only one item is in work; the next is accepted in the cycle after the result registers.
// Synchronous reset clears trip state and loads defaults.
`timescale 1ns / 1ps
`default_nettype none

module diesel_trip_fuel_economy (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [13:0]                      engine_rpm,
  input  wire logic [7:0]                       manifold_kpa,
  input  wire logic [6:0]                       load_pct,
  input  wire logic signed [8:0]                intake_temp_c,
  input  wire logic [7:0]                       speed_kph,
  input  wire logic [31:0]                      time_ms,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [15:0]                           avg_kml_centi,
  output logic [10:0]                           boost_mbar,
  output logic                                  accumulated,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [dtfe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [dtfe_pkg::CFG_DATA_W-1:0]  cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_EVAL, S_M1, S_M2, S_M3, S_M4, S_FSTART, S_FWAIT,
    S_ACC, S_AM1, S_AM2, S_ASTART, S_AWAIT, S_OUT
  } state_t;

  dtfe_pkg::cfg_t      cfg;
  dtfe_pkg::div_stat_t div_stat;
  state_t              state;

  logic [13:0]        rpm_r;
  logic [7:0]         map_r;
  logic [6:0]         load_r;
  logic signed [8:0]  iat_r;
  logic [7:0]         kph_r;
  logic [31:0]        now_r;

  logic [31:0]                     last_time;
  logic                            time_valid;
  logic [dtfe_pkg::FUEL_W-1:0]     trip_fuel_nl;
  logic [dtfe_pkg::DIST_W-1:0]     trip_dist_mm;
  logic [15:0]                     avg_kml_held;
  logic [10:0]                     boost_held;
  logic                            acc;

  logic [15:0] dt;
  logic [21:0] ra;
  logic [31:0] rb;
  logic [13:0] afr;
  logic [12:0] temp;
  logic [23:0] rx;
  logic [53:0] num54;
  logic [26:0] den27;
  logic [26:0] rx5;
  logic [63:0] fuel_num;
  logic [37:0] fuel_den;
  logic [22:0] dq;
  logic [22:0] dist_step;
  logic [63:0] fuel;
  logic [36:0] avg_pl;
  logic [36:0] avg_ph;
  logic [56:0] avg_num;

  logic                               div_start;
  logic [dtfe_pkg::DIV_NUM_W-1:0]     div_num;
  logic [dtfe_pkg::DIV_DEN_W-1:0]     div_den;
  logic [dtfe_pkg::DIV_NUM_W-1:0]     div_quot;

  logic [31:0]        dt_full;
  logic [13:0]        base_x10;
  logic [13:0]        floor_x10;
  logic [14:0]        load_x_slope;
  logic signed [16:0] afr_lin;
  logic [13:0]        afr_sel;
  logic [13:0]        afr_clamped;
  logic signed [13:0] temp_full;
  logic [54:0]        dq_prod;
  logic [26:0]        dist_rem;
  logic [64:0]        fuel_sum;
  logic [40:0]        dist_sum;
  logic signed [12:0] boost_lin;
  logic [10:0]        boost_clamped;
  logic               out_free;

  dtfe_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dtfe_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quot  (div_quot),
    .stat  (div_stat)
  );

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  assign div_start = (state == S_FSTART) || (state == S_ASTART);
  assign div_num   = (state == S_ASTART) ? dtfe_pkg::DIV_NUM_W'(avg_num) : fuel_num;
  assign div_den   = (state == S_ASTART) ? trip_fuel_nl
                                         : dtfe_pkg::DIV_DEN_W'(fuel_den);

  assign dt_full = now_r - last_time;

  assign base_x10     = 14'(cfg.afr_base_tenths) * 14'd10;
  assign floor_x10    = 14'(cfg.afr_floor_tenths) * 14'd10;
  assign load_x_slope = 15'(load_r) * 15'(cfg.afr_slope_hundredths);
  assign afr_lin      = $signed({3'b000, base_x10}) - $signed({2'b00, load_x_slope});
  assign afr_sel      = (afr_lin < $signed({3'b000, floor_x10})) ? floor_x10
                                                                  : afr_lin[13:0];
  assign afr_clamped  = (afr_sel == 14'd0) ? 14'd1 : afr_sel;

  assign temp_full = $signed({{5{iat_r[8]}}, iat_r}) * 14'sd10
                     + $signed(dtfe_pkg::TEMP_OFFSET);

  assign dq_prod  = 55'(rx5) * 55'(dtfe_pkg::RECIP18);
  assign dist_rem = rx5 - 27'(dq) * 27'(dtfe_pkg::MM_DIVISOR);

  assign fuel_sum = 65'(trip_fuel_nl) + 65'(fuel);
  assign dist_sum = 41'(trip_dist_mm) + 41'(dist_step);

  assign boost_lin = $signed({1'b0, 12'(map_r) * 12'd10})
                     - $signed({2'b00, cfg.atm_tenths_kpa});
  assign boost_clamped = (boost_lin < 13'sd0) ? 11'd0 :
                         (boost_lin > $signed({2'b00, dtfe_pkg::BOOST_MAX}))
                           ? dtfe_pkg::BOOST_MAX : boost_lin[10:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      last_time    <= '0;
      time_valid   <= 1'b0;
      trip_fuel_nl <= '0;
      trip_dist_mm <= '0;
      avg_kml_held <= '0;
      boost_held   <= '0;
      acc          <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            rpm_r <= engine_rpm;
            map_r <= manifold_kpa;
            load_r <= load_pct;
            iat_r <= intake_temp_c;
            kph_r <= speed_kph;
            now_r <= time_ms;
            acc   <= 1'b0;
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (rpm_r <= cfg.min_rpm) begin
            time_valid <= 1'b0;
            boost_held <= '0;
            state      <= S_OUT;
          end else if (!time_valid) begin
            time_valid <= 1'b1;
            last_time  <= now_r;
            state      <= S_OUT;
          end else begin
            last_time <= now_r;
            dt        <= dt_full[15:0];
            if (dt_full != 32'd0 && dt_full < 32'(cfg.max_dt_ms)) begin
              state <= S_M1;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_M1: begin
          ra    <= 22'(rpm_r) * 22'(map_r);
          rb    <= 32'(cfg.maf_coeff_micro) * 32'(dt);
          afr   <= afr_clamped;
          temp  <= temp_full[12:0];
          rx    <= 24'(kph_r) * 24'(dt);
          state <= S_M2;
        end
        S_M2: begin
          num54 <= 54'(ra) * 54'(rb);
          den27 <= 27'(temp) * 27'(afr);
          rx5   <= 27'(rx) * 27'd5;
          state <= S_M3;
        end
        S_M3: begin
          fuel_num <= 64'(num54) * 64'(dtfe_pkg::NL_PER_UL);
          fuel_den <= 38'(den27) * 38'(cfg.fuel_density_gpl);
          dq       <= dq_prod[dtfe_pkg::RECIP18_SHIFT +: 23];
          state    <= S_M4;
        end
        S_M4: begin
          dist_step <= (dist_rem >= 27'(dtfe_pkg::MM_DIVISOR)) ? dq + 23'd1 : dq;
          if (fuel_den == 38'd0) begin
            fuel  <= '0;
            state <= S_ACC;
          end else begin
            state <= S_FSTART;
          end
        end
        S_FSTART: begin
          state <= S_FWAIT;
        end
        S_FWAIT: begin
          if (div_stat.done) begin
            fuel  <= div_quot;
            state <= S_ACC;
          end
        end
        S_ACC: begin
          trip_fuel_nl <= (fuel_sum > 65'(dtfe_pkg::FUEL_MAX)) ? dtfe_pkg::FUEL_MAX
                                                               : fuel_sum[47:0];
          trip_dist_mm <= (dist_sum > 41'(dtfe_pkg::DIST_MAX)) ? dtfe_pkg::DIST_MAX
                                                               : dist_sum[39:0];
          boost_held   <= boost_clamped;
          acc          <= 1'b1;
          state        <= S_AM1;
        end
        S_AM1: begin
          avg_pl <= 37'(trip_dist_mm[19:0]) * 37'(dtfe_pkg::AVG_SCALE);
          avg_ph <= 37'(trip_dist_mm[39:20]) * 37'(dtfe_pkg::AVG_SCALE);
          if (trip_fuel_nl > dtfe_pkg::FUEL_MIN_NL) begin
            state <= S_AM2;
          end else begin
            state <= S_OUT;
          end
        end
        S_AM2: begin
          avg_num <= (57'(avg_ph) << 20) + 57'(avg_pl);
          state   <= S_ASTART;
        end
        S_ASTART: begin
          state <= S_AWAIT;
        end
        S_AWAIT: begin
          if (div_stat.done) begin
            avg_kml_held <= (div_quot[63:16] != 48'd0) ? 16'hFFFF : div_quot[15:0];
            state        <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            avg_kml_centi <= avg_kml_held;
            boost_mbar    <= boost_held;
            accumulated   <= acc;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The shared divider is only started when it is free.
  assert property (@(posedge clk) disable iff (rst) div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // Trip fuel total never goes down outside reset.
  assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> trip_fuel_nl >= $past(trip_fuel_nl))
    else $error("trip fuel decreased");

  // Boost is only nonzero while a timing mark is held.
  assert property (@(posedge clk) disable iff (rst) !time_valid |-> boost_held == 11'd0)
    else $error("boost held without valid timing mark");

endmodule

`default_nettype wire

// ===== dv/dtfe_trip_checker.sv =====
// Checker for the diesel trip fuel economy block: watches the sample, result and
// register channels, predicts each result in fixed point and compares field by field.
// Depends on dtfe_pkg for the register index names and the register struct.
`timescale 1ns / 1ps

module dtfe_trip_checker (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  input  wire logic                             in_stall,
  input  wire logic [13:0]                      engine_rpm,
  input  wire logic [7:0]                       manifold_kpa,
  input  wire logic [6:0]                       load_pct,
  input  wire logic signed [8:0]                intake_temp_c,
  input  wire logic [7:0]                       speed_kph,
  input  wire logic [31:0]                      time_ms,
  input  wire logic                             out_valid,
  input  wire logic                             out_stall,
  input  wire logic [15:0]                      avg_kml_centi,
  input  wire logic [10:0]                      boost_mbar,
  input  wire logic                             accumulated,
  input  wire logic                             cfg_valid,
  input  wire logic                             cfg_ready,
  input  wire logic [dtfe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [dtfe_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                                    fail_count,
  output int                                    outstanding
);

  localparam logic [63:0] FUEL_CAP   = (64'd1 << 48) - 64'd1;
  localparam logic [63:0] DIST_CAP   = (64'd1 << 40) - 64'd1;
  localparam logic [47:0] FUEL_GATE  = 48'd100000;

  typedef struct packed {
    logic [15:0] avg_kml;
    logic [10:0] boost;
    logic        acc;
  } economy_t;

  economy_t        economy_q[$];
  economy_t        want;
  economy_t        got;
  dtfe_pkg::cfg_t  regs;
  logic [31:0]     mark_time;
  logic            mark_valid;
  logic [47:0]     fuel_nl;
  logic [39:0]     dist_mm;
  logic [15:0]     avg_hold;
  logic [10:0]     boost_hold;
  int              errs = 0;

  function automatic logic [63:0] capped_sum(logic [63:0] a, logic [63:0] b, logic [63:0] cap);
    if (a > cap) a = cap;
    if (b > cap - a) return cap;
    return a + b;
  endfunction

  function automatic economy_t economy_step(logic [13:0] rpm, logic [7:0] map,
                                            logic [6:0] load, logic signed [8:0] temp_c,
                                            logic [7:0] kph, logic [31:0] now);
    logic [31:0] dt;
    int          temp_dk;
    int          afr;
    int          afr_min;
    int          bst;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] fuel;
    logic [63:0] step_mm;
    logic [63:0] avg;
    economy_t    r;
    r.acc = 1'b0;
    if (rpm <= regs.min_rpm) begin
      mark_valid = 1'b0;
      boost_hold = '0;
    end else if (!mark_valid) begin
      mark_valid = 1'b1;
      mark_time = now;
    end else begin
      dt = now - mark_time;
      mark_time = now;
      if (dt != 0 && dt < 32'(regs.max_dt_ms)) begin
        temp_dk = int'(temp_c) * 10 + 2732;
        afr = int'(regs.afr_base_tenths) * 10 - int'(load) * int'(regs.afr_slope_hundredths);
        afr_min = int'(regs.afr_floor_tenths) * 10;
        if (afr < afr_min) afr = afr_min;
        if (afr < 1) afr = 1;
        num = 64'(rpm) * 64'(map) * 64'(regs.maf_coeff_micro) * 64'(dt) * 64'd1000;
        den = 64'(temp_dk) * 64'(afr) * 64'(regs.fuel_density_gpl);
        fuel = (den != 0) ? num / den : 64'd0;
        step_mm = (64'(kph) * 64'(dt) * 64'd5) / 64'd18;
        fuel_nl = 48'(capped_sum(64'(fuel_nl), fuel, FUEL_CAP));
        dist_mm = 40'(capped_sum(64'(dist_mm), step_mm, DIST_CAP));
        if (fuel_nl > FUEL_GATE) begin
          avg = (64'(dist_mm) * 64'd100000) / 64'(fuel_nl);
          avg_hold = (avg > 64'hFFFF) ? 16'hFFFF : avg[15:0];
        end
        bst = int'(map) * 10 - int'(regs.atm_tenths_kpa);
        if (bst < 0) bst = 0;
        if (bst > 2047) bst = 2047;
        boost_hold = 11'(bst);
        r.acc = 1'b1;
      end
    end
    r.avg_kml = avg_hold;
    r.boost = boost_hold;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      economy_q.delete();
      regs.min_rpm = 14'd400;
      regs.max_dt_ms = 16'd2000;
      regs.afr_base_tenths = 10'd500;
      regs.afr_slope_hundredths = 8'd32;
      regs.afr_floor_tenths = 10'd160;
      regs.maf_coeff_micro = 16'd1850;
      regs.fuel_density_gpl = 11'd835;
      regs.atm_tenths_kpa = 11'd1013;
      mark_time = '0;
      mark_valid = 1'b0;
      fuel_nl = '0;
      dist_mm = '0;
      avg_hold = '0;
      boost_hold = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (dtfe_pkg::cfg_reg_t'(cfg_index))
          dtfe_pkg::REG_MIN_RPM:   regs.min_rpm = cfg_data[13:0];
          dtfe_pkg::REG_MAX_DT_MS: regs.max_dt_ms = cfg_data[15:0];
          dtfe_pkg::REG_AFR_BASE:  regs.afr_base_tenths = cfg_data[9:0];
          dtfe_pkg::REG_AFR_SLOPE: regs.afr_slope_hundredths = cfg_data[7:0];
          dtfe_pkg::REG_AFR_FLOOR: regs.afr_floor_tenths = cfg_data[9:0];
          dtfe_pkg::REG_MAF_COEFF: regs.maf_coeff_micro = cfg_data[15:0];
          dtfe_pkg::REG_FUEL_DENS: regs.fuel_density_gpl = cfg_data[10:0];
          dtfe_pkg::REG_ATM_KPA:   regs.atm_tenths_kpa = cfg_data[10:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        economy_q.push_back(economy_step(engine_rpm, manifold_kpa, load_pct, intake_temp_c,
                                         speed_kph, time_ms));
      end
      if (out_valid && !out_stall) begin
        got.avg_kml = avg_kml_centi;
        got.boost = boost_mbar;
        got.acc = accumulated;
        if (economy_q.size() == 0) begin
          errs++;
          $error("result with no sample waiting: avg_kml_centi %0d boost_mbar %0d accumulated %0d",
                 got.avg_kml, got.boost, got.acc);
        end else begin
          want = economy_q.pop_front();
          if (got.avg_kml !== want.avg_kml) begin
            errs++;
            $error("avg_kml_centi: expected %0d, actual %0d", want.avg_kml, got.avg_kml);
          end
          if (got.boost !== want.boost) begin
            errs++;
            $error("boost_mbar: expected %0d, actual %0d", want.boost, got.boost);
          end
          if (got.acc !== want.acc) begin
            errs++;
            $error("accumulated: expected %0d, actual %0d", want.acc, got.acc);
          end
        end
      end
    end
    fail_count <= errs;
    outstanding <= economy_q.size();
  end

endmodule

// ===== dv/tb.sv =====
// Top of the testbench for diesel_trip_fuel_economy: clock, reset, register
// programming, engine sample stimulus and result stalls; the verdict comes from
// dtfe_trip_checker. Depends on dtfe_pkg, the block and the checker.
`timescale 1ns / 1ps

module tb;

  localparam int LIMIT_CYCLES = 1000000;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [13:0]                     engine_rpm = '0;
  logic [7:0]                      manifold_kpa = '0;
  logic [6:0]                      load_pct = '0;
  logic signed [8:0]               intake_temp_c = '0;
  logic [7:0]                      speed_kph = '0;
  logic [31:0]                     time_ms = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [15:0]                     avg_kml_centi;
  logic [10:0]                     boost_mbar;
  logic                            accumulated;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [dtfe_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [dtfe_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int          fail_count;
  int          outstanding;
  int          cycle_count = 0;
  int          gate_rpm = 400;
  int          dt_limit = 2000;
  int          burst_left = 1;
  int          stall_mode = 0;
  int          mode_left = 0;
  int          hold_left = 0;
  logic [31:0] clock_ms;

  diesel_trip_fuel_economy dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .engine_rpm(engine_rpm), .manifold_kpa(manifold_kpa), .load_pct(load_pct),
    .intake_temp_c(intake_temp_c), .speed_kph(speed_kph), .time_ms(time_ms),
    .out_valid(out_valid), .out_stall(out_stall),
    .avg_kml_centi(avg_kml_centi), .boost_mbar(boost_mbar), .accumulated(accumulated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  dtfe_trip_checker trip_chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .engine_rpm(engine_rpm), .manifold_kpa(manifold_kpa), .load_pct(load_pct),
    .intake_temp_c(intake_temp_c), .speed_kph(speed_kph), .time_ms(time_ms),
    .out_valid(out_valid), .out_stall(out_stall),
    .avg_kml_centi(avg_kml_centi), .boost_mbar(boost_mbar), .accumulated(accumulated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(2, 0);
      mode_left <= $urandom_range(512, 64);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(2, 0) == 0);
      default: begin
        if (hold_left == 0) begin
          out_stall <= ~out_stall;
          hold_left <= $urandom_range(30, 1);
        end else begin
          hold_left <= hold_left - 1;
        end
      end
    endcase
  end

  task automatic send(input logic [13:0] rpm, input logic [7:0] map, input logic [6:0] load,
                      input logic signed [8:0] temp_c, input logic [7:0] kph,
                      input logic [31:0] stamp);
    in_valid <= 1'b1;
    engine_rpm <= rpm;
    manifold_kpa <= map;
    load_pct <= load;
    intake_temp_c <= temp_c;
    speed_kph <= kph;
    time_ms <= stamp;
    do @(posedge clk); while (in_stall);
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat (($urandom_range(4, 0) == 0) ? $urandom_range(180, 20) : $urandom_range(8, 1))
        @(posedge clk);
      burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(60, 20) : $urandom_range(6, 1);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input dtfe_pkg::cfg_reg_t r, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= value[15:0];
    do @(posedge clk); while (!cfg_ready);
    if (r == dtfe_pkg::REG_MIN_RPM) gate_rpm = value;
    if (r == dtfe_pkg::REG_MAX_DT_MS) dt_limit = value;
  endtask

  task automatic program_regs(input int min_rpm, input int max_dt, input int base,
                              input int slope, input int floor_t, input int maf,
                              input int dens, input int atm);
    write_reg(dtfe_pkg::REG_MIN_RPM, min_rpm);
    write_reg(dtfe_pkg::REG_MAX_DT_MS, max_dt);
    write_reg(dtfe_pkg::REG_AFR_BASE, base);
    write_reg(dtfe_pkg::REG_AFR_SLOPE, slope);
    write_reg(dtfe_pkg::REG_AFR_FLOOR, floor_t);
    write_reg(dtfe_pkg::REG_MAF_COEFF, maf);
    write_reg(dtfe_pkg::REG_FUEL_DENS, dens);
    write_reg(dtfe_pkg::REG_ATM_KPA, atm);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int pick(input int lo, input int hi, input int typ_lo, input int typ_hi);
    case ($urandom_range(7, 0))
      0: return lo;
      1: return hi;
      default: return $urandom_range(typ_hi, typ_lo);
    endcase
  endfunction

  task automatic random_sample();
    int                kind;
    logic [31:0]       dt;
    logic [13:0]       rpm;
    logic [6:0]        load;
    logic signed [8:0] temp_c;
    kind = $urandom_range(9, 0);
    if (kind == 0 || gate_rpm >= 16383) rpm = 14'($urandom_range(gate_rpm, 0));
    else rpm = 14'($urandom_range(16383, gate_rpm + 1));
    if (kind == 1) dt = 0;
    else if (kind == 2 || dt_limit <= 1)
      dt = ($urandom_range(1, 0) == 1) ? $urandom : $urandom_range(65535, dt_limit);
    else if (kind == 3) dt = $urandom_range(dt_limit - 1, 1);
    else dt = $urandom_range((dt_limit - 1 < 3000) ? dt_limit - 1 : 3000, 1);
    clock_ms = clock_ms + dt;
    load = ($urandom_range(9, 0) == 0) ? 7'($urandom_range(127, 0)) : 7'($urandom_range(100, 0));
    temp_c = ($urandom_range(9, 0) == 0) ? 9'($urandom) : 9'($urandom_range(255, 0) - 40);
    send(rpm, 8'($urandom), load, temp_c, 8'($urandom), clock_ms);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset register values: gate, first sample, zero and too long intervals.
    send(14'd0, 8'd255, 7'd100, 9'sd215, 8'd255, 32'hFFFF_FFFF);
    send(14'd400, 8'd255, 7'd100, 9'sd215, 8'd255, 32'd0);
    send(14'd401, 8'd100, 7'd50, 9'sd20, 8'd80, 32'd100);
    send(14'd16383, 8'd100, 7'd50, 9'sd20, 8'd80, 32'd100);
    send(14'd16383, 8'd100, 7'd50, 9'sd20, 8'd80, 32'd2100);
    // Distance with no fuel, then a sample that lifts fuel past the average gate.
    send(14'd16383, 8'd0, 7'd0, -9'sd40, 8'd255, 32'd4099);
    send(14'd16383, 8'd0, 7'd0, -9'sd40, 8'd255, 32'd6098);
    send(14'd3000, 8'd200, 7'd0, 9'sd27, 8'd255, 32'd7598);
    send(14'd3000, 8'd200, 7'd100, 9'sd27, 8'd100, 32'd9597);
    send(14'd3000, 8'd200, 7'd127, 9'sh100, 8'd0, 32'd9598);
    send(14'd16383, 8'd255, 7'd100, 9'sd255, 8'd255, 32'd11596);
    // Timestamp wrap.
    send(14'd5000, 8'd150, 7'd30, 9'sd0, 8'd60, 32'hFFFF_FFF0);
    send(14'd5000, 8'd150, 7'd30, 9'sd0, 8'd60, 32'd5);
    send(14'd0, 8'd150, 7'd30, 9'sd0, 8'd60, 32'd10);
    send(14'd16383, 8'd101, 7'd30, 9'sd0, 8'd60, 32'd50);
    send(14'd16383, 8'd101, 7'd30, 9'sd0, 8'd60, 32'd51);

    // Extreme registers: rpm gate at zero, floor zero, fuel saturation, boost saturation.
    settle();
    program_regs(0, 65535, 0, 255, 0, 65535, 1, 0);
    send(14'd0, 8'd255, 7'd100, 9'sh100, 8'd255, 32'd60);
    send(14'd1, 8'd255, 7'd100, 9'sh100, 8'd255, 32'd0);
    send(14'd16383, 8'd255, 7'd100, 9'sh100, 8'd255, 32'd65534);
    send(14'd16383, 8'd255, 7'd100, 9'sh100, 8'd255, 32'd131069);
    send(14'd16383, 8'd255, 7'd100, 9'sh100, 8'd255, 32'd131070);

    settle();
    program_regs(16383, 1, 1023, 0, 1023, 0, 2047, 2047);
    send(14'd16383, 8'd255, 7'd0, 9'sd215, 8'd255, 32'd200);

    settle();
    program_regs(0, 1, 1023, 0, 1023, 0, 2047, 2047);
    send(14'd5, 8'd200, 7'd0, 9'sd20, 8'd100, 32'd300);
    send(14'd5, 8'd200, 7'd0, 9'sd20, 8'd100, 32'd301);

    clock_ms = $urandom;
    for (int phase = 0; phase < 10; phase++) begin
      settle();
      if (phase == 0) begin
        program_regs(400, 2000, 500, 32, 160, 1850, 835, 1013);
      end else begin
        program_regs(pick(0, 16383, 0, 1500), pick(1, 65535, 200, 5000),
                     pick(0, 1023, 300, 700), pick(0, 255, 0, 64), pick(0, 1023, 100, 300),
                     pick(0, 65535, 500, 8000), pick(1, 2047, 700, 900),
                     pick(0, 2047, 900, 1100));
      end
      repeat (74) random_sample();
    end

    settle();
    repeat (200) @(posedge clk);
    if (outstanding != 0) $error("%0d expected results never arrived", outstanding);
    if (fail_count == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
